### sv/tvm_pkg.sv
// Shared constants, types and the sine quarter-wave table of the three-voice tone mixer.
`default_nettype none

package tvm_pkg;

	localparam int PHASE_BITS      = 32;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int SAMPLE_BITS     = 16;

	localparam int VOICES  = 3;
	localparam int VOICE_W = 2;
	localparam int STEP_W  = 31;
	localparam int GAIN_W  = 15;
	localparam int CFG_W   = 31;
	localparam int CFG_IDX_W = 2;

	// Sine table geometry and sample arithmetic.
	localparam int QUARTER_W   = TABLE_ADDR_BITS - 2;
	localparam int QUARTER_LEN = 1 << QUARTER_W;
	localparam int MAG_W       = 15;
	localparam int ENTRY_W     = MAG_W + 1;
	localparam int PROD_W      = ENTRY_W + GAIN_W + 1;
	localparam int ACC_W       = PROD_W + 2;
	localparam int ROUND_SHIFT = 31 - SAMPLE_BITS;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned SINE_PEAK   = 64'd32767;

	// Result queue at the output.
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

	localparam logic [VOICE_W-1:0] VOICE_ONE   = 2'd0;
	localparam logic [VOICE_W-1:0] VOICE_TWO   = 2'd1;
	localparam logic [VOICE_W-1:0] VOICE_THREE = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VOICE1_STEP = 2'd0,
		REG_VOICE2_STEP = 2'd1,
		REG_VOICE3_STEP = 2'd2,
		REG_VOICE_GAIN  = 2'd3
	} cfg_reg_t;

	localparam logic [STEP_W-1:0] VOICE1_STEP_RESET = 31'd50964998;
	localparam logic [STEP_W-1:0] VOICE2_STEP_RESET = 31'd60606761;
	localparam logic [STEP_W-1:0] VOICE3_STEP_RESET = 31'd76354974;
	localparam logic [GAIN_W-1:0] VOICE_GAIN_RESET  = 15'd9830;

	// Control that travels with one voice through the pipeline.
	typedef struct packed {
		logic               valid;
		logic [VOICE_W-1:0] idx;
		logic               gate;
		logic               first;
		logic               last;
	} voice_ctl_t;

	typedef logic [MAG_W-1:0] quarter_rom_t [QUARTER_LEN];

	// Taylor series of sine up to the eleventh power in Q30, scaled to Q1.15.
	function automatic logic [MAG_W-1:0] quarter_value(input int unsigned r);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		x  = (64'(r) * HALF_PI_Q30) >> QUARTER_W;
		x2 = (x * x) >> 30;
		t  = ((x * x2) >> 30) / 64'd6;
		s  = x - t;
		t  = ((t * x2) >> 30) / 64'd20;
		s  = s + t;
		t  = ((t * x2) >> 30) / 64'd42;
		s  = s - t;
		t  = ((t * x2) >> 30) / 64'd72;
		s  = s + t;
		t  = ((t * x2) >> 30) / 64'd110;
		s  = s - t;
		v  = (s * SINE_PEAK + (64'd1 << 29)) >> 30;
		if (v > SINE_PEAK) begin
			v = SINE_PEAK;
		end
		return v[MAG_W-1:0];
	endfunction

	function automatic quarter_rom_t build_quarter_rom();
		quarter_rom_t rom;
		for (int i = 0; i < QUARTER_LEN; i++) begin
			rom[i] = quarter_value(i);
		end
		return rom;
	endfunction

	localparam quarter_rom_t     QUARTER_ROM = build_quarter_rom();
	localparam logic [MAG_W-1:0] QUARTER_TOP = quarter_value(QUARTER_LEN);

endpackage

`default_nettype wire

### sv/tvm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tvm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### sv/tvm_sine.sv
// Sine table lookup by quarter-wave symmetry with a registered signed Q1.15 result.
`default_nettype none

module tvm_sine (
	input  wire logic                                clk,
	input  wire logic [tvm_pkg::TABLE_ADDR_BITS-1:0] addr,
	output logic signed [tvm_pkg::ENTRY_W-1:0]       entry
);

	logic [1:0]                      quad;
	logic [tvm_pkg::QUARTER_W-1:0]   r;
	logic [tvm_pkg::QUARTER_W:0]     r_fold;
	logic [tvm_pkg::MAG_W-1:0]       mag;
	logic signed [tvm_pkg::ENTRY_W-1:0] mag_s;

	assign quad = addr[tvm_pkg::TABLE_ADDR_BITS-1 -: 2];
	assign r    = addr[tvm_pkg::QUARTER_W-1:0];

	// Odd quadrants run the quarter wave backwards; only the very top index reaches the peak.
	assign r_fold = quad[0] ? ((tvm_pkg::QUARTER_W+1)'(tvm_pkg::QUARTER_LEN) - {1'b0, r})
	                        : {1'b0, r};
	assign mag    = r_fold[tvm_pkg::QUARTER_W] ? tvm_pkg::QUARTER_TOP
	                                           : tvm_pkg::QUARTER_ROM[r_fold[tvm_pkg::QUARTER_W-1:0]];
	assign mag_s  = $signed({1'b0, mag});

	always_ff @(posedge clk) begin
		entry <= quad[1] ? -mag_s : mag_s;
	end

endmodule

`default_nettype wire

### sv/three_voice_tone_mixer.sv
// Top level of the three-voice sine tone mixer.
// Each request is one sample tick carrying three gate bits and yields one saturated 16-bit
// sample. The three phase accumulators live in a small phase memory; one voice per cycle is
// read, advanced by its tuning word and written back, then looked up in the shared sine
// table and scaled by the shared gain multiplier. A tick holds the voice sequencer while
// its three voices issue; a new request can be taken as the third issues. Its sample then
// passes the phase, address, sine, product and sum registers to an output queue of four;
// requests also stall when it, counting samples in flight, is full. Phase entries read
// as zero until first written after reset, so no clearing pass is needed. Configuration
// writes take effect immediately and should be made only while the block is idle.
`default_nettype none

module three_voice_tone_mixer (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               wr_en,
	input  wire logic [tvm_pkg::CFG_IDX_W-1:0]      wr_index,
	input  wire logic [tvm_pkg::CFG_W-1:0]          wr_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               gate_one,
	input  wire logic                               gate_two,
	input  wire logic                               gate_three,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [tvm_pkg::SAMPLE_BITS-1:0]  mixed_sample
);

	// Configuration registers.
	logic [tvm_pkg::STEP_W-1:0] voice1_step_q;
	logic [tvm_pkg::STEP_W-1:0] voice2_step_q;
	logic [tvm_pkg::STEP_W-1:0] voice3_step_q;
	logic [tvm_pkg::GAIN_W-1:0] voice_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice1_step_q <= tvm_pkg::VOICE1_STEP_RESET;
			voice2_step_q <= tvm_pkg::VOICE2_STEP_RESET;
			voice3_step_q <= tvm_pkg::VOICE3_STEP_RESET;
			voice_gain_q  <= tvm_pkg::VOICE_GAIN_RESET;
		end else if (wr_en) begin
			case (tvm_pkg::cfg_reg_t'(wr_index))
				tvm_pkg::REG_VOICE1_STEP: voice1_step_q <= wr_data[tvm_pkg::STEP_W-1:0];
				tvm_pkg::REG_VOICE2_STEP: voice2_step_q <= wr_data[tvm_pkg::STEP_W-1:0];
				tvm_pkg::REG_VOICE3_STEP: voice3_step_q <= wr_data[tvm_pkg::STEP_W-1:0];
				tvm_pkg::REG_VOICE_GAIN:  voice_gain_q  <= wr_data[tvm_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Voice sequencer: issues voices one, two, three of the held tick on consecutive cycles.
	logic                         busy_q;
	logic [tvm_pkg::VOICE_W-1:0]  voice_q;
	logic [2:0]                   gates_q;
	logic [tvm_pkg::OUT_PTR_W:0]  credit_q;
	logic                         in_fire;
	logic                         out_fire;
	logic                         last_issue;
	tvm_pkg::voice_ctl_t          ctl_s0;

	assign last_issue = busy_q && (voice_q == tvm_pkg::VOICE_THREE);
	assign in_ready   = (!busy_q || last_issue)
	                    && (credit_q < (tvm_pkg::OUT_PTR_W+1)'(tvm_pkg::OUT_DEPTH));
	assign in_fire    = in_valid && in_ready;
	assign out_fire   = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			voice_q  <= tvm_pkg::VOICE_ONE;
			credit_q <= '0;
		end else begin
			if (in_fire) begin
				busy_q  <= 1'b1;
				voice_q <= tvm_pkg::VOICE_ONE;
			end else if (last_issue) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				voice_q <= voice_q + 1'b1;
			end
			case ({in_fire, out_fire})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			gates_q <= {gate_three, gate_two, gate_one};
		end
	end

	always_comb begin
		ctl_s0.valid = busy_q;
		ctl_s0.idx   = voice_q;
		ctl_s0.first = (voice_q == tvm_pkg::VOICE_ONE);
		ctl_s0.last  = (voice_q == tvm_pkg::VOICE_THREE);
		case (voice_q)
			tvm_pkg::VOICE_ONE:   ctl_s0.gate = gates_q[0];
			tvm_pkg::VOICE_TWO:   ctl_s0.gate = gates_q[1];
			tvm_pkg::VOICE_THREE: ctl_s0.gate = gates_q[2];
			default:              ctl_s0.gate = 1'b0;
		endcase
	end

	// Phase memory. An entry is written the cycle after its read, before the same voice is
	// read again, so no forwarding is needed.
	logic [tvm_pkg::PHASE_BITS-1:0]   phase_rd;
	logic [tvm_pkg::PHASE_BITS-1:0]   phase_old;
	logic [tvm_pkg::PHASE_BITS-1:0]   phase_new;
	logic [tvm_pkg::STEP_W-1:0]       step_sel;
	logic [tvm_pkg::VOICES-1:0]       phase_ok_q;
	tvm_pkg::voice_ctl_t              ctl_s1;

	tvm_ram #(
		.WIDTH(tvm_pkg::PHASE_BITS),
		.DEPTH(tvm_pkg::VOICES)
	) u_phase_ram (
		.clk  (clk),
		.we   (ctl_s1.valid),
		.waddr(ctl_s1.idx),
		.wdata(phase_new),
		.raddr(voice_q),
		.rdata(phase_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1     <= '0;
			phase_ok_q <= '0;
		end else begin
			ctl_s1 <= ctl_s0;
			if (ctl_s1.valid) begin
				phase_ok_q[ctl_s1.idx] <= 1'b1;
			end
		end
	end

	always_comb begin
		case (ctl_s1.idx)
			tvm_pkg::VOICE_ONE:   step_sel = voice1_step_q;
			tvm_pkg::VOICE_TWO:   step_sel = voice2_step_q;
			tvm_pkg::VOICE_THREE: step_sel = voice3_step_q;
			default:              step_sel = '0;
		endcase
	end

	assign phase_old = phase_ok_q[ctl_s1.idx] ? phase_rd : '0;
	assign phase_new = phase_old + tvm_pkg::PHASE_BITS'(step_sel);

	// Table address, then the sine lookup whose result arrives with stage 3.
	logic [tvm_pkg::TABLE_ADDR_BITS-1:0] taddr_s2;
	logic signed [tvm_pkg::ENTRY_W-1:0]  entry_s3;
	tvm_pkg::voice_ctl_t                 ctl_s2;
	tvm_pkg::voice_ctl_t                 ctl_s3;

	always_ff @(posedge clk) begin
		taddr_s2 <= phase_new[tvm_pkg::PHASE_BITS-1 -: tvm_pkg::TABLE_ADDR_BITS];
	end

	tvm_sine u_sine (
		.clk  (clk),
		.addr (taddr_s2),
		.entry(entry_s3)
	);

	// Gain multiply, then accumulation over the three voices of a tick.
	logic signed [tvm_pkg::PROD_W-1:0] prod_s4;
	logic signed [tvm_pkg::ACC_W-1:0]  term;
	logic signed [tvm_pkg::ACC_W-1:0]  acc_next;
	logic signed [tvm_pkg::ACC_W-1:0]  acc_q;
	logic signed [tvm_pkg::ACC_W-1:0]  total_s5;
	logic                              total_v_s5;
	tvm_pkg::voice_ctl_t               ctl_s4;

	always_ff @(posedge clk) begin
		prod_s4 <= tvm_pkg::PROD_W'(entry_s3 * $signed({1'b0, voice_gain_q}));
	end

	assign term     = ctl_s4.gate ? tvm_pkg::ACC_W'(prod_s4) : '0;
	assign acc_next = (ctl_s4.first ? '0 : acc_q) + term;

	always_ff @(posedge clk) begin
		if (ctl_s4.valid) begin
			acc_q <= acc_next;
		end
		if (ctl_s4.valid && ctl_s4.last) begin
			total_s5 <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2     <= '0;
			ctl_s3     <= '0;
			ctl_s4     <= '0;
			total_v_s5 <= 1'b0;
		end else begin
			ctl_s2     <= ctl_s1;
			ctl_s3     <= ctl_s2;
			ctl_s4     <= ctl_s3;
			total_v_s5 <= ctl_s4.valid && ctl_s4.last;
		end
	end

	// Round to the sample width and saturate.
	localparam logic signed [tvm_pkg::ACC_W-1:0] SAMPLE_HI =
		tvm_pkg::ACC_W'((64'sd1 <<< (tvm_pkg::SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [tvm_pkg::ACC_W-1:0] SAMPLE_LO =
		tvm_pkg::ACC_W'(-(64'sd1 <<< (tvm_pkg::SAMPLE_BITS - 1)));
	localparam logic signed [tvm_pkg::ACC_W-1:0] ROUND_BIAS =
		tvm_pkg::ACC_W'(64'sd1 <<< (tvm_pkg::ROUND_SHIFT - 1));

	logic signed [tvm_pkg::ACC_W-1:0]       rounded;
	logic signed [tvm_pkg::SAMPLE_BITS-1:0] sample;

	assign rounded = (total_s5 + ROUND_BIAS) >>> tvm_pkg::ROUND_SHIFT;

	always_comb begin
		if (rounded > SAMPLE_HI) begin
			sample = SAMPLE_HI[tvm_pkg::SAMPLE_BITS-1:0];
		end else if (rounded < SAMPLE_LO) begin
			sample = SAMPLE_LO[tvm_pkg::SAMPLE_BITS-1:0];
		end else begin
			sample = rounded[tvm_pkg::SAMPLE_BITS-1:0];
		end
	end

	// Output queue; the request credit guarantees it never overflows.
	logic signed [tvm_pkg::SAMPLE_BITS-1:0] queue_q [tvm_pkg::OUT_DEPTH];
	logic [tvm_pkg::OUT_PTR_W-1:0]          wr_ptr_q;
	logic [tvm_pkg::OUT_PTR_W-1:0]          rd_ptr_q;
	logic [tvm_pkg::OUT_PTR_W:0]            fill_q;

	always_ff @(posedge clk) begin
		if (total_v_s5) begin
			queue_q[wr_ptr_q] <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (total_v_s5) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_fire) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({total_v_s5, out_fire})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: ;
			endcase
		end
	end

	assign out_valid    = (fill_q != '0);
	assign mixed_sample = queue_q[rd_ptr_q];

endmodule

`default_nettype wire

### bench/tvm_checker.sv
// Sample predictor and scoreboard that watches the ports of the three-voice tone mixer.
`default_nettype none

module tvm_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [tvm_pkg::CFG_IDX_W-1:0]     wr_index,
	input  wire logic [tvm_pkg::CFG_W-1:0]         wr_data,
	input  wire logic                              in_valid,
	input  wire logic                              in_ready,
	input  wire logic                              gate_one,
	input  wire logic                              gate_two,
	input  wire logic                              gate_three,
	input  wire logic                              out_valid,
	input  wire logic                              out_ready,
	input  wire logic signed [tvm_pkg::SAMPLE_BITS-1:0] mixed_sample,
	output int unsigned                            fault_total,
	output int unsigned                            samples_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int              QTR_BITS    = tvm_pkg::TABLE_ADDR_BITS - 2;
	localparam int unsigned     QTR_LEN     = 1 << QTR_BITS;
	localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
	localparam longint unsigned FULL_SCALE  = 64'd32767;
	localparam int              ROUND_W     = 31 - tvm_pkg::SAMPLE_BITS;
	localparam int              REPORT_MAX  = 10;

	logic [tvm_pkg::PHASE_BITS-1:0]         phase_acc [tvm_pkg::VOICES];
	logic [tvm_pkg::STEP_W-1:0]             step_word [tvm_pkg::VOICES];
	logic [tvm_pkg::GAIN_W-1:0]             gain_word;
	logic signed [tvm_pkg::SAMPLE_BITS-1:0] samples_due [$];

	// Quarter-wave magnitude from a Taylor series in Q30, scaled to Q1.15.
	function automatic int quarter_mag(input int unsigned r);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned acc;
		longint unsigned v;
		x = (64'(r) * PI_HALF_Q30) >> QTR_BITS;
		x2 = (x * x) >> 30;
		term = x;
		acc = x;
		for (int n = 1; n <= 5; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - term;
			end else begin
				acc = acc + term;
			end
		end
		v = (acc * FULL_SCALE + (64'd1 << 29)) >> 30;
		if (v > FULL_SCALE) begin
			v = FULL_SCALE;
		end
		return int'(v);
	endfunction

	function automatic int sine_lookup(input logic [tvm_pkg::TABLE_ADDR_BITS-1:0] addr);
		logic [1:0]  quad;
		int unsigned r;
		int          mag;
		quad = addr[tvm_pkg::TABLE_ADDR_BITS-1 -: 2];
		r = 32'(addr[QTR_BITS-1:0]);
		if (quad[0]) begin
			r = QTR_LEN - r;
		end
		mag = quarter_mag(r);
		return quad[1] ? -mag : mag;
	endfunction

	// Advances all three phases and returns the mixed sample of one tick.
	function automatic logic signed [tvm_pkg::SAMPLE_BITS-1:0] mix_tick(
			input logic [tvm_pkg::VOICES-1:0] gates);
		longint                              total;
		longint                              rounded;
		logic [tvm_pkg::TABLE_ADDR_BITS-1:0] addr;
		total = 0;
		for (int k = 0; k < tvm_pkg::VOICES; k++) begin
			phase_acc[k] = phase_acc[k] + tvm_pkg::PHASE_BITS'(step_word[k]);
			addr = phase_acc[k][tvm_pkg::PHASE_BITS-1 -: tvm_pkg::TABLE_ADDR_BITS];
			if (gates[k]) begin
				total = total + longint'(sine_lookup(addr)) * longint'(gain_word);
			end
		end
		rounded = (total + (longint'(1) << (ROUND_W - 1))) >>> ROUND_W;
		if (rounded > (longint'(1) << (tvm_pkg::SAMPLE_BITS - 1)) - 1) begin
			rounded = (longint'(1) << (tvm_pkg::SAMPLE_BITS - 1)) - 1;
		end
		if (rounded < -(longint'(1) << (tvm_pkg::SAMPLE_BITS - 1))) begin
			rounded = -(longint'(1) << (tvm_pkg::SAMPLE_BITS - 1));
		end
		return rounded[tvm_pkg::SAMPLE_BITS-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [tvm_pkg::SAMPLE_BITS-1:0] want;
		if (!arst_n) begin
			for (int k = 0; k < tvm_pkg::VOICES; k++) begin
				phase_acc[k] = '0;
			end
			step_word[0] = tvm_pkg::VOICE1_STEP_RESET;
			step_word[1] = tvm_pkg::VOICE2_STEP_RESET;
			step_word[2] = tvm_pkg::VOICE3_STEP_RESET;
			gain_word = tvm_pkg::VOICE_GAIN_RESET;
			samples_due.delete();
			fault_total = 0;
			samples_owed <= 0;
		end else begin
			if (wr_en) begin
				case (tvm_pkg::cfg_reg_t'(wr_index))
					tvm_pkg::REG_VOICE1_STEP: step_word[0] = wr_data[tvm_pkg::STEP_W-1:0];
					tvm_pkg::REG_VOICE2_STEP: step_word[1] = wr_data[tvm_pkg::STEP_W-1:0];
					tvm_pkg::REG_VOICE3_STEP: step_word[2] = wr_data[tvm_pkg::STEP_W-1:0];
					tvm_pkg::REG_VOICE_GAIN:  gain_word = wr_data[tvm_pkg::GAIN_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				samples_due.push_back(mix_tick({gate_three, gate_two, gate_one}));
			end
			if (out_valid && out_ready) begin
				if (samples_due.size() == 0) begin
					fault_total++;
					if (fault_total <= REPORT_MAX) begin
						$display("%0t: sample %0d with no tick pending", $realtime,
							mixed_sample);
					end
				end else begin
					want = samples_due.pop_front();
					if (mixed_sample !== want) begin
						fault_total++;
						if (fault_total <= REPORT_MAX) begin
							$display("%0t: mixed_sample expected %0d got %0d", $realtime,
								want, mixed_sample);
						end
					end
				end
			end
			samples_owed <= samples_due.size();
		end
	end

endmodule

`default_nettype wire

### bench/tb_top.sv
// Stimulus, reset, clock and verdict for the three-voice tone mixer bench.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned                LIMIT_CYCLES = 200000;
	localparam int                         RAND_PHASES  = 6;
	localparam int                         PHASE_TICKS  = 200;
	localparam int                         GATE_COMBOS  = 8;
	localparam int                         HOLD_AT      = 517;
	localparam int                         HOLD_CYCLES  = 300;
	localparam int                         TAIL_CYCLES  = 16;
	localparam logic [31:0]                PEAK_PHASE   = 32'h4020_0000;
	localparam logic [tvm_pkg::STEP_W-1:0] STEP_MAX     = '1;
	localparam logic [tvm_pkg::CFG_W-1:0]  GAIN_FULL    = 31'h7FFF_FFFF;
	localparam logic [tvm_pkg::CFG_W-1:0]  GAIN_NONE    = 31'h7FFF_8000;

	typedef enum int {
		READY_STEADY,
		READY_COIN,
		READY_SPARSE
	} ready_mode_t;

	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   wr_en = 1'b0;
	logic [tvm_pkg::CFG_IDX_W-1:0]          wr_index = tvm_pkg::REG_VOICE1_STEP;
	logic [tvm_pkg::CFG_W-1:0]              wr_data = '0;
	logic                                   in_valid = 1'b0;
	logic                                   in_ready;
	logic                                   gate_one = 1'b0;
	logic                                   gate_two = 1'b0;
	logic                                   gate_three = 1'b0;
	logic                                   out_valid;
	logic                                   out_ready = 1'b0;
	logic signed [tvm_pkg::SAMPLE_BITS-1:0] mixed_sample;
	int unsigned                            fault_total;
	int unsigned                            samples_owed;
	int unsigned                            ticks_sent = 0;
	int unsigned                            cycle_cnt = 0;

	three_voice_tone_mixer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.gate_one     (gate_one),
		.gate_two     (gate_two),
		.gate_three   (gate_three),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mixed_sample (mixed_sample)
	);

	tvm_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.gate_one     (gate_one),
		.gate_two     (gate_two),
		.gate_three   (gate_three),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mixed_sample (mixed_sample),
		.fault_total  (fault_total),
		.samples_owed (samples_owed)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT_CYCLES) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Offers one request and returns at the edge that accepts it.
	task automatic send_tick(input logic [2:0] gates);
		in_valid <= 1'b1;
		gate_one <= gates[0];
		gate_two <= gates[1];
		gate_three <= gates[2];
		do @(posedge clk); while (!in_ready);
		ticks_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (samples_owed != 0);
	endtask

	task automatic write_reg(input tvm_pkg::cfg_reg_t idx,
			input logic [tvm_pkg::CFG_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
	endtask

	task automatic program_mix(input logic [tvm_pkg::STEP_W-1:0] s1,
			input logic [tvm_pkg::STEP_W-1:0] s2, input logic [tvm_pkg::STEP_W-1:0] s3,
			input logic [tvm_pkg::CFG_W-1:0] gain_data);
		write_reg(tvm_pkg::REG_VOICE1_STEP, s1);
		write_reg(tvm_pkg::REG_VOICE2_STEP, s2);
		write_reg(tvm_pkg::REG_VOICE3_STEP, s3);
		write_reg(tvm_pkg::REG_VOICE_GAIN, gain_data);
		wr_en <= 1'b0;
	endtask

	function automatic logic [tvm_pkg::STEP_W-1:0] pick_step();
		case ($urandom_range(0, 7))
			0, 1, 2: return tvm_pkg::STEP_W'($urandom);
			3, 4:    return tvm_pkg::STEP_W'($urandom_range(0, 1 << 16));
			5:       return STEP_MAX;
			6:       return '0;
			default: return STEP_MAX - tvm_pkg::STEP_W'($urandom_range(0, 1 << 12));
		endcase
	endfunction

	// Output side: stretches of steady, coin-flip and sparse readiness, plus one long hold-off
	// that lets the output queue fill so the input backs up.
	initial begin
		ready_mode_t mode;
		int          span;
		bit          held;
		held = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && ticks_sent >= HOLD_AT) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			case ($urandom_range(0, 3))
				0, 1:    mode = READY_STEADY;
				2:       mode = READY_COIN;
				default: mode = READY_SPARSE;
			endcase
			span = $urandom_range(8, 80);
			repeat (span) begin
				case (mode)
					READY_STEADY: out_ready <= 1'b1;
					READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
					default:      out_ready <= ($urandom_range(0, 7) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		logic [31:0] align [3];
		logic [tvm_pkg::CFG_W-1:0] gain_data;
		int left;
		int burst;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every gate combination with the reset tuning.
		for (int g = 0; g < GATE_COMBOS; g++) begin
			send_tick(3'(g));
		end

		// Steer all three phases onto the positive peak in one tick, at full gain.
		align[0] = PEAK_PHASE - GATE_COMBOS * 32'(tvm_pkg::VOICE1_STEP_RESET);
		align[1] = PEAK_PHASE - GATE_COMBOS * 32'(tvm_pkg::VOICE2_STEP_RESET);
		align[2] = PEAK_PHASE - GATE_COMBOS * 32'(tvm_pkg::VOICE3_STEP_RESET);
		wait_drained();
		program_mix(align[0][tvm_pkg::STEP_W-1:0], align[1][tvm_pkg::STEP_W-1:0],
			align[2][tvm_pkg::STEP_W-1:0], GAIN_FULL);
		send_tick(3'b111);

		// Almost half a turn per tick swings between the peaks, so the sum clips both ways,
		// and the phases wrap.
		wait_drained();
		program_mix(STEP_MAX, STEP_MAX, STEP_MAX, GAIN_FULL);
		repeat (4) send_tick(3'b111);
		send_tick(3'b001);
		send_tick(3'b000);

		wait_drained();
		program_mix('0, '0, '0, GAIN_NONE);
		send_tick(3'b111);
		send_tick(3'b010);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case ($urandom_range(0, 3))
				0:       gain_data = {(tvm_pkg::CFG_W - tvm_pkg::GAIN_W)'($urandom),
				                      {tvm_pkg::GAIN_W{1'b1}}};
				1:       gain_data = {(tvm_pkg::CFG_W - tvm_pkg::GAIN_W)'($urandom),
				                      {tvm_pkg::GAIN_W{1'b0}}};
				default: gain_data = tvm_pkg::CFG_W'($urandom);
			endcase
			wait_drained();
			program_mix(pick_step(), pick_step(), pick_step(), gain_data);
			left = PHASE_TICKS;
			while (left > 0) begin
				burst = $urandom_range(1, 24);
				if (burst > left) begin
					burst = left;
				end
				repeat (burst) send_tick(3'($urandom_range(0, 7)));
				left -= burst;
				if ($urandom_range(0, 39) == 0) begin
					wait_drained();
				end else if ($urandom_range(0, 3) != 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 9)) @(posedge clk);
				end
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fault_total == 0 && samples_owed == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
sv/tvm_pkg.sv
sv/tvm_ram.sv
sv/tvm_sine.sv
sv/three_voice_tone_mixer.sv
bench/tvm_checker.sv
bench/tb_top.sv
